// ===== src/lant_pkg.sv =====
// Shared types and constants for the Langton's ant step block.
// Depends on nothing; lant_step_calc and langton_ant_step_top import it.
`default_nettype none

package lant_pkg;

   localparam int COORD_W = 9;
   localparam int CMP_W   = 14;

   localparam logic [COORD_W-1:0] START_RESET = 9'd256;

   // Operation codes carried in the mode field of a request.
   typedef enum logic [1:0] {
      MODE_STEP  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_PLACE = 2'd2
   } mode_type;

   // Headings: the direction the ant faces.
   localparam logic [1:0] HEAD_XM = 2'd0;
   localparam logic [1:0] HEAD_YP = 2'd1;
   localparam logic [1:0] HEAD_XP = 2'd2;
   localparam logic [1:0] HEAD_YM = 2'd3;

   // Register indexes on the configuration port.
   localparam logic CSR_START_X = 1'b0;
   localparam logic CSR_START_Y = 1'b1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COORD_W-1:0] read_x;
      logic [COORD_W-1:0] read_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] ant_x;
      logic [COORD_W-1:0] ant_y;
      logic [1:0]         heading;
      logic               cell_value;
      logic               blocked;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/lant_grid_mem.sv =====
// One-bit grid memory: one write port and one read port with registered read data.
// Depends on nothing beyond its parameters.
`default_nettype none

module lant_grid_mem #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data
);

   logic grid_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
   end

   // A read of the entry written at the same edge returns the old value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= grid_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/lant_clear_seq.sv =====
// Clearing sequencer: walks every grid entry once after reset, one per cycle.
// Depends on nothing beyond its parameters.
`default_nettype none

module lant_clear_seq #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  wire logic    clock,
   input  wire logic    reset,
   output logic         busy,
   output logic [AW-1:0] addr
);

   logic          busy_ff;
   logic          busy_in;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + AW'(1);
         if (addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign busy = busy_ff;
   assign addr = addr_ff;

endmodule

`default_nettype wire

// ===== src/lant_step_calc.sv =====
// Next-state logic of the ant: turn, cell flip, bounded move, restart and read result.
// Depends on lant_pkg.
`default_nettype none

module lant_step_calc #(
   parameter int GRID_W = 512,
   parameter int GRID_H = 512,
   parameter int XW     = 9,
   parameter int YW     = 9
) (
   input  wire logic [1:0]                  mode,
   input  wire logic                        in_range,
   input  wire logic                        cur_cell,
   input  wire logic [XW-1:0]               pos_x,
   input  wire logic [YW-1:0]               pos_y,
   input  wire logic [1:0]                  dir,
   input  wire logic [lant_pkg::COORD_W-1:0] start_x,
   input  wire logic [lant_pkg::COORD_W-1:0] start_y,
   output logic [XW-1:0]                    pos_x_nx,
   output logic [YW-1:0]                    pos_y_nx,
   output logic [1:0]                       dir_nx,
   output logic                             wr_en,
   output logic                             cell_nx,
   output logic                             cell_value,
   output logic                             blocked
);

   import lant_pkg::*;

   logic [XW-1:0] start_x_c;
   logic [YW-1:0] start_y_c;
   logic [1:0]    turned;

   // A start coordinate beyond the grid saturates to the last column or row.
   assign start_x_c = (CMP_W'(start_x) >= CMP_W'(GRID_W)) ? XW'(GRID_W - 1) : XW'(start_x);
   assign start_y_c = (CMP_W'(start_y) >= CMP_W'(GRID_H)) ? YW'(GRID_H - 1) : YW'(start_y);

   // Turn one way on a clear cell and the other way on a set cell.
   assign turned = cur_cell ? (dir - 2'd1) : (dir + 2'd1);

   always_comb begin
      pos_x_nx   = pos_x;
      pos_y_nx   = pos_y;
      dir_nx     = dir;
      wr_en      = 1'b0;
      cell_nx    = 1'b0;
      cell_value = 1'b0;
      blocked    = 1'b0;
      unique case (mode)
         MODE_STEP: begin
            wr_en      = 1'b1;
            cell_nx    = ~cur_cell;
            cell_value = ~cur_cell;
            dir_nx     = turned;
            case (turned)
               HEAD_XM: begin
                  if (pos_x == '0) blocked = 1'b1;
                  else pos_x_nx = pos_x - XW'(1);
               end
               HEAD_YP: begin
                  if (pos_y == YW'(GRID_H - 1)) blocked = 1'b1;
                  else pos_y_nx = pos_y + YW'(1);
               end
               HEAD_XP: begin
                  if (pos_x == XW'(GRID_W - 1)) blocked = 1'b1;
                  else pos_x_nx = pos_x + XW'(1);
               end
               default: begin
                  // Heading minus y.
                  if (pos_y == '0) blocked = 1'b1;
                  else pos_y_nx = pos_y - YW'(1);
               end
            endcase
         end
         MODE_READ: begin
            cell_value = in_range & cur_cell;
         end
         MODE_PLACE: begin
            pos_x_nx = start_x_c;
            pos_y_nx = start_y_c;
            dir_nx   = HEAD_XM;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/langton_ant_step_top.sv =====
// Langton's ant step engine, top level.
// A request waits in the work stage for its grid read, then moves to the output register.
// Throughput: one request per cycle without output stalls; the next read is addressed from
// the move being committed and a cell written at that edge is bypassed, so no bubble is needed.
// Reset: a clearing pass over all GRID_H * 2**clog2(GRID_W) entries (262144 at defaults) zeroes
// the grid; requests are held off until it ends, configuration writes are taken throughout.
`default_nettype none

module langton_ant_step_top #(
   parameter int GRID_W = 512,
   parameter int GRID_H = 512
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire lant_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output lant_pkg::rsp_type                 rsp_data,
   input  wire logic                         csr_we,
   input  wire logic                         csr_addr,
   input  wire logic [lant_pkg::COORD_W-1:0] csr_wdata
);

   import lant_pkg::*;

   localparam int XW    = (GRID_W > 1) ? $clog2(GRID_W) : 1;
   localparam int YW    = (GRID_H > 1) ? $clog2(GRID_H) : 1;
   localparam int AW    = XW + YW;
   // Each row occupies a power-of-two slot so the address is a plain concatenation.
   localparam int DEPTH = GRID_H * (2 ** XW);
   localparam int START_X_RST = (int'(START_RESET) >= GRID_W) ? GRID_W - 1 : int'(START_RESET);
   localparam int START_Y_RST = (int'(START_RESET) >= GRID_H) ? GRID_H - 1 : int'(START_RESET);

   // Configuration registers.
   logic [COORD_W-1:0] start_x_ff, start_x_in;
   logic [COORD_W-1:0] start_y_ff, start_y_in;

   // Architectural ant state, updated when a request leaves the work stage.
   logic [XW-1:0] pos_x_ff, pos_x_in;
   logic [YW-1:0] pos_y_ff, pos_y_in;
   logic [1:0]    dir_ff, dir_in;

   // Work stage: the request whose grid read is in flight.
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_mode_ff;
   logic       s1_range_ff;
   logic       fwd_hit_ff;
   logic       fwd_val_ff;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic          clr_busy;
   logic [AW-1:0] clr_addr;

   logic          accept;
   logic          out_free;
   logic          s1_commit;
   logic          mem_rd_data;
   logic          cell_rd;
   logic          rd_in_range;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] ant_addr;
   logic [XW-1:0] nx_pos_x;
   logic [YW-1:0] nx_pos_y;
   logic [XW-1:0] base_x;
   logic [YW-1:0] base_y;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_wr_data;

   logic [1:0]    calc_dir;
   logic          calc_wr;
   logic          calc_cell;
   logic          calc_cv;
   logic          calc_blk;

   lant_clear_seq #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_clear (
      .clock(clock),
      .reset(reset),
      .busy (clr_busy),
      .addr (clr_addr)
   );

   lant_grid_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (accept),
      .rd_addr(rd_addr),
      .rd_data(mem_rd_data)
   );

   // A write to the entry read by the previous transfer at the same edge is bypassed,
   // since the memory returns the old value in that case.
   assign cell_rd = fwd_hit_ff ? fwd_val_ff : mem_rd_data;

   lant_step_calc #(
      .GRID_W(GRID_W),
      .GRID_H(GRID_H),
      .XW    (XW),
      .YW    (YW)
   ) u_calc (
      .mode      (s1_mode_ff),
      .in_range  (s1_range_ff),
      .cur_cell  (cell_rd),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .dir       (dir_ff),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .pos_x_nx  (nx_pos_x),
      .pos_y_nx  (nx_pos_y),
      .dir_nx    (calc_dir),
      .wr_en     (calc_wr),
      .cell_nx   (calc_cell),
      .cell_value(calc_cv),
      .blocked   (calc_blk)
   );

   // Handshake. The work stage moves on whenever the output register is empty or being
   // drained, and a new request enters as the previous one leaves, so the pipe never bubbles.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_commit = s1_valid_ff && out_free;
   assign req_ready = !clr_busy && (!s1_valid_ff || out_free);
   assign accept    = req_valid && req_ready;

   // Read address for the incoming request. A step reads the cell under the ant; when the
   // work stage is committing at the same edge, that is the position it is about to produce.
   assign rd_in_range = (CMP_W'(req_data.read_x) < CMP_W'(GRID_W)) &&
                        (CMP_W'(req_data.read_y) < CMP_W'(GRID_H));
   assign base_x   = s1_valid_ff ? nx_pos_x : pos_x_ff;
   assign base_y   = s1_valid_ff ? nx_pos_y : pos_y_ff;
   assign rd_addr  = (req_data.mode == MODE_READ) ?
                     {YW'(req_data.read_y), XW'(req_data.read_x)} : {base_y, base_x};
   assign ant_addr = {pos_y_ff, pos_x_ff};

   // The clearing pass owns the write port until it finishes; no request is in flight then.
   assign mem_wr_en   = clr_busy || (s1_commit && calc_wr);
   assign mem_wr_addr = clr_busy ? clr_addr : ant_addr;
   assign mem_wr_data = clr_busy ? 1'b0 : calc_cell;

   // Configuration writes.
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_START_X: start_x_in = csr_wdata;
            CSR_START_Y: start_y_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Ant state and stage occupancy.
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      dir_in   = dir_ff;
      if (s1_commit) begin
         pos_x_in = nx_pos_x;
         pos_y_in = nx_pos_y;
         dir_in   = calc_dir;
      end
      s1_valid_in = accept ? 1'b1 : (s1_commit ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= START_RESET;
         start_y_ff   <= START_RESET;
         pos_x_ff     <= XW'(START_X_RST);
         pos_y_ff     <= YW'(START_Y_RST);
         dir_ff       <= HEAD_XM;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         dir_ff       <= dir_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work-stage payload, captured with the transfer. The bypass flag records that the
   // committing step writes the very entry this request reads.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_data.mode;
         s1_range_ff <= rd_in_range;
         fwd_hit_ff  <= s1_commit && calc_wr && (rd_addr == ant_addr);
         fwd_val_ff  <= calc_cell;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (s1_commit) begin
         rsp_data_ff.ant_x      <= COORD_W'(nx_pos_x);
         rsp_data_ff.ant_y      <= COORD_W'(nx_pos_y);
         rsp_data_ff.heading    <= calc_dir;
         rsp_data_ff.cell_value <= calc_cv;
         rsp_data_ff.blocked    <= calc_blk;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No request may enter while the grid is being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !accept)
      else $error("request transfer during grid clearing");

   // A request in the work stage that cannot leave stays there.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("work stage dropped a request");

   // The bypass is armed only by a transfer that meets a committing step.
   a_fwd_needs_commit: assert property (@(posedge clock) disable iff (reset)
      (accept && !s1_commit) |=> !fwd_hit_ff)
      else $error("bypass flag set without a committing step");

   // Ant state changes only when a request leaves the work stage.
   a_state_on_commit: assert property (@(posedge clock) disable iff (reset)
      !s1_commit |=> ($stable(pos_x_ff) && $stable(pos_y_ff) && $stable(dir_ff)))
      else $error("ant state changed without a commit");

endmodule

`default_nettype wire

// ===== tb/sv/langton_ant_step_top_tb.sv =====
// Self-checking testbench for the Langton's ant step engine (langton_ant_step_top).
// A directed table and a random walk are checked against an in-bench model of the ant.
// Depends on lant_pkg for the request and response types and their codes.

module langton_ant_step_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lant_pkg::*;

   localparam int GRID_W          = 512;
   localparam int GRID_H          = 512;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 330;
   // The grid clearing pass after reset covers 262144 entries with no transfer,
   // so the watchdog allows about three such passes.
   localparam int STALL_LIMIT     = 800000;
   localparam int SETTLE_CYCLES   = 4;

   // The mode field has two bits; the top code is not assigned to any operation.
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef enum bit {ROW_REQ, ROW_CSR} row_kind_type;

   // One row of the directed table: either a register write or a request. A request row
   // carries a typed-in response when that response is obvious; otherwise the model's
   // prediction is used.
   typedef struct {
      row_kind_type       kind;
      logic               reg_index;
      logic [COORD_W-1:0] reg_value;
      req_type            item;
      bit                 typed;
      rsp_type            result;
   } stim_row_type;

   bit                 clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_we    = 1'b0;
   logic               csr_addr  = 1'b0;
   logic [COORD_W-1:0] csr_wdata = '0;

   // Model state of the ant, its grid and the two start registers.
   bit   [GRID_W-1:0]  grid_rows [GRID_H];
   logic [COORD_W-1:0] ant_col;
   logic [COORD_W-1:0] ant_row;
   logic [1:0]         ant_dir;
   logic [COORD_W-1:0] start_col = START_RESET;
   logic [COORD_W-1:0] start_row = START_RESET;

   rsp_type            pending_rsps [$];
   int                 mismatches     = 0;
   int                 stalled_cycles = 0;
   int                 send_idle_pct  = 0;
   int                 recv_idle_pct  = 0;
   int                 mode_count [4] = '{0, 0, 0, 0};
   int                 blocked_count  = 0;
   int                 start_count    = 0;

   // Directed rows. The ant starts at the middle of the grid with the reset start
   // registers, then is moved to the low corner and to the high corner so that both
   // kinds of blocked move show up early.
   stim_row_type directed_rows [24] = '{
      // Fresh grid: a read of the low corner sees 0 and the ant sits at the start.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd0, 9'd0},
        1'b1, '{9'd256, 9'd256, HEAD_XM, 1'b0, 1'b0}},
      // The spare mode only reports the ant.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_SPARE, 9'd511, 9'd511},
        1'b1, '{9'd256, 9'd256, HEAD_XM, 1'b0, 1'b0}},
      // First tick on a white cell: paint it, turn to plus y and move.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd511, 9'd0},
        1'b1, '{9'd256, 9'd257, HEAD_YP, 1'b1, 1'b0}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd256, 9'd256},
        1'b1, '{9'd256, 9'd257, HEAD_YP, 1'b1, 1'b0}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_PLACE, 9'd0, 9'd511},
        1'b1, '{9'd256, 9'd256, HEAD_XM, 1'b0, 1'b0}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd511, 9'd511}, 1'b0, '0},
      '{ROW_CSR, CSR_START_X, 9'd0, '0, 1'b0, '0},
      '{ROW_CSR, CSR_START_Y, 9'd0, '0, 1'b0, '0},
      // A register write alone must not move the ant.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_SPARE, 9'd0, 9'd0}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_PLACE, 9'd511, 9'd511},
        1'b1, '{9'd0, 9'd0, HEAD_XM, 1'b0, 1'b0}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0},
        1'b1, '{9'd0, 9'd1, HEAD_YP, 1'b1, 1'b0}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_PLACE, 9'd0, 9'd0},
        1'b1, '{9'd0, 9'd0, HEAD_XM, 1'b0, 1'b0}},
      // Black cell at the low corner: turn to minus y, which leaves the grid.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0},
        1'b1, '{9'd0, 9'd0, HEAD_YM, 1'b0, 1'b1}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0}, 1'b0, '0},
      '{ROW_CSR, CSR_START_X, 9'd511, '0, 1'b0, '0},
      '{ROW_CSR, CSR_START_Y, 9'd511, '0, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_PLACE, 9'd0, 9'd0},
        1'b1, '{9'd511, 9'd511, HEAD_XM, 1'b0, 1'b0}},
      // White cell at the high corner: turn to plus y, which leaves the grid.
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0},
        1'b1, '{9'd511, 9'd511, HEAD_YP, 1'b1, 1'b1}},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd0, 9'd511}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd511, 9'd0}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_STEP, 9'd0, 9'd0}, 1'b0, '0},
      '{ROW_REQ, CSR_START_X, 9'd0, '{MODE_READ, 9'd511, 9'd511}, 1'b0, '0}
   };

   langton_ant_step_top #(
      .GRID_W(GRID_W),
      .GRID_H(GRID_H)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Put the ant on the start cell, facing minus x. A start beyond the grid saturates.
   function automatic void place_ant();
      ant_col = (start_col >= GRID_W) ? COORD_W'(GRID_W - 1) : start_col;
      ant_row = (start_row >= GRID_H) ? COORD_W'(GRID_H - 1) : start_row;
      ant_dir = HEAD_XM;
   endfunction

   // Apply one request to the model and return the response the block should give.
   function automatic rsp_type advance_ant(input req_type item);
      rsp_type r;
      bit      cur_cell;
      r = '0;
      case (item.mode)
         MODE_STEP: begin
            // Invert the cell under the ant and turn: right on white, left on black.
            cur_cell = grid_rows[ant_row][ant_col];
            grid_rows[ant_row][ant_col] = ~cur_cell;
            ant_dir = cur_cell ? ant_dir - 2'd1 : ant_dir + 2'd1;
            r.cell_value = ~cur_cell;
            // A move off the grid leaves the ant where it is and raises blocked.
            case (ant_dir)
               HEAD_XM: begin
                  if (ant_col == 0) r.blocked = 1'b1;
                  else ant_col = ant_col - 1'b1;
               end
               HEAD_YP: begin
                  if (ant_row >= GRID_H - 1) r.blocked = 1'b1;
                  else ant_row = ant_row + 1'b1;
               end
               HEAD_XP: begin
                  if (ant_col >= GRID_W - 1) r.blocked = 1'b1;
                  else ant_col = ant_col + 1'b1;
               end
               default: begin
                  if (ant_row == 0) r.blocked = 1'b1;
                  else ant_row = ant_row - 1'b1;
               end
            endcase
         end
         MODE_READ: begin
            if (item.read_x < GRID_W && item.read_y < GRID_H)
               r.cell_value = grid_rows[item.read_y][item.read_x];
         end
         MODE_PLACE: begin
            place_ant();
         end
         default: begin
         end
      endcase
      r.ant_x   = ant_col;
      r.ant_y   = ant_row;
      r.heading = ant_dir;
      return r;
   endfunction

   // Offer one request with a random gap in front of it, wait for its transfer, then record
   // the expected response. Valid is left high after the transfer, so that a back-to-back
   // request never lowers and raises it within one time step.
   task automatic push_request(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = advance_ant(item);
      pending_rsps.push_back(typed ? typed_rsp : predicted);
      mode_count[item.mode]++;
      if (predicted.blocked) blocked_count++;
   endtask

   // Stop offering requests and wait until every expected response has had its transfer.
   // At least one edge passes, so the caller's next drive lands in a later time step.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   // Start registers are written only while the block is idle.
   task automatic write_start(input logic index, input logic [COORD_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (index == CSR_START_X) start_col = value;
      else start_row = value;
   endtask

   // Response side: check each response transfer against the oldest expectation and
   // drive ready with the current stall rate. Outputs are sampled at the edge, before
   // the block's registers update.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            $error("response transfer with nothing expected: %h", rsp_data);
            mismatches++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.ant_x !== want.ant_x) begin
               $error("ant_x: expected %0d, got %0d", want.ant_x, rsp_data.ant_x);
               mismatches++;
            end
            if (rsp_data.ant_y !== want.ant_y) begin
               $error("ant_y: expected %0d, got %0d", want.ant_y, rsp_data.ant_y);
               mismatches++;
            end
            if (rsp_data.heading !== want.heading) begin
               $error("heading: expected %0d, got %0d", want.heading, rsp_data.heading);
               mismatches++;
            end
            if (rsp_data.cell_value !== want.cell_value) begin
               $error("cell_value: expected %0d, got %0d", want.cell_value,
                      rsp_data.cell_value);
               mismatches++;
            end
            if (rsp_data.blocked !== want.blocked) begin
               $error("blocked: expected %0d, got %0d", want.blocked, rsp_data.blocked);
               mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: any transfer on either channel restarts the count of quiet cycles.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("langton_ant_step_top: mismatch");
         $finish;
      end
   end

   initial begin
      req_type            item;
      int                 pick;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;

      place_ant();

      // Synchronous reset first. The block then clears its grid, and request
      // transfers are held off until that pass is over.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_start(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            push_request(directed_rows[i].item, directed_rows[i].typed,
                         directed_rows[i].result);
         end
      end

      // Random part. The first four phases start the ant in each corner so that blocked
      // moves are frequent; the last two use random start cells. Idling is heavy on the
      // response side first, then on the request side, then off.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 55 : 0;
         recv_idle_pct = (phase < 2) ? 55 : (phase < 4) ? 24 : 0;
         case (phase)
            0: begin
               col = '0;
               row = '0;
            end
            1: begin
               col = '1;
               row = '1;
            end
            2: begin
               col = '0;
               row = '1;
            end
            3: begin
               col = '1;
               row = '0;
            end
            default: begin
               col = COORD_W'($urandom_range(0, GRID_W - 1));
               row = COORD_W'($urandom_range(0, GRID_H - 1));
            end
         endcase
         write_start(CSR_START_X, col);
         write_start(CSR_START_Y, row);
         start_count++;

         item = '{MODE_PLACE, COORD_W'($urandom), COORD_W'($urandom)};
         push_request(item, 1'b0, '0);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Halfway through, hold off requests until the pipeline is empty.
            if (n == ITEMS_PER_PHASE / 2) drain_results();

            // Mostly ticks, with reads and restarts mixed in; a restart now and then keeps
            // the ant near its start corner, where the grid edge blocks it.
            pick        = $urandom_range(0, 99);
            item.read_x = COORD_W'($urandom);
            item.read_y = COORD_W'($urandom);
            if (pick < 70) begin
               item.mode = MODE_STEP;
            end else if (pick < 85) begin
               item.mode = MODE_READ;
               // Half of the reads look at the trail around the ant, where cells are set.
               if ($urandom_range(0, 1)) begin
                  item.read_x = ant_col + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
                  item.read_y = ant_row + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
               end
            end else if (pick < 95) begin
               item.mode = MODE_PLACE;
            end else begin
               item.mode = MODE_SPARE;
            end
            push_request(item, 1'b0, '0);
         end
      end

      // Let the last responses arrive, then a settling wait for anything stray.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d ticks (%0d blocked), %0d reads, %0d restarts, %0d spare-mode requests.",
               mode_count[MODE_STEP], blocked_count, mode_count[MODE_READ],
               mode_count[MODE_PLACE], mode_count[MODE_SPARE]);
      $display("Start cell was reprogrammed for %0d random phases after the directed table.",
               start_count);
      if (mismatches == 0 && pending_rsps.size() == 0) begin
         $display("langton_ant_step_top: match");
      end else begin
         $display("langton_ant_step_top: mismatch");
      end
      $finish;
   end

endmodule
